FILE: sv/srht_pkg.sv
// Package for the shared region handle table: sizes, action codes, slot entry type.
// No dependencies.
package srht_pkg;
   localparam int SLOTS      = 16;
   localparam int SLOT_PAGES = 16;
   localparam int PAGE_BYTES = 4096;
   localparam int TASKS      = 32;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PAGE_SH    = $clog2(PAGE_BYTES);
   localparam logic [32:0] SLOT_CAP = 33'(SLOT_PAGES) * 33'(PAGE_BYTES);

   localparam logic [2:0] ACT_CREATE  = 3'd0;
   localparam logic [2:0] ACT_MAP     = 3'd1;
   localparam logic [2:0] ACT_UNMAP   = 3'd2;
   localparam logic [2:0] ACT_PIN     = 3'd3;
   localparam logic [2:0] ACT_UNPIN   = 3'd4;
   localparam logic [2:0] ACT_CLEANUP = 3'd5;

   typedef struct packed {
      logic        valid;
      logic [15:0] gen;
      logic [16:0] size;
      logic [4:0]  pages;
      logic [31:0] owners;
      logic [15:0] pins;
   } slot_type;
endpackage

FILE: sv/shared_region_handle_table_top.sv
// Top level of the shared region handle table: handshakes, slot memory, sequencer.
// Depends on srht_pkg.
//
//  channel | dir | payload
//  req_    | in  | tdata: action, task_id, token, size_bytes, offset, length
//  rsp_    | out | tdata: status, token_out, address, size_out, first_page, page_span,
//          |     |        first_offset
//  csr_    | in  | region_base
//
// Map, unmap, pin, unpin: read, modify and write back, output. Create walks the slots
// and stops at the first free one; cleanup walks every slot, reading and then handling
// each one. A refused create or cleanup and an unknown action go straight to output.
// The next request is taken in the cycle after the response is accepted. After reset a
// clearing pass zeroes every slot before the first request. A held result does not
// block csr writes.
module shared_region_handle_table_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata, // action, task_id, token, size_bytes, offset, length
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata, // status, token_out, address, size_out, first_page,
                                   // page_span, first_offset
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);
   import srht_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_WALK  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   slot_type mem [SLOTS];
   slot_type rd_ff;

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W:0]   cnt_ff, cnt_in;
   logic [31:0]       base_ff;
   logic [135:0]      req_ff;
   logic [95:0]       rsp_ff, rsp_in;
   logic              rspv_ff, rspv_in;

   logic              we;
   logic [SLOT_W-1:0] waddr, raddr;
   slot_type          wdata;

   logic [2:0]  act;
   logic [4:0]  tid;
   logic [31:0] tok, sz, off, len;
   assign act = req_ff[2:0];
   assign tid = req_ff[7:3];
   assign tok = req_ff[39:8];
   assign sz  = req_ff[71:40];
   assign off = req_ff[103:72];
   assign len = req_ff[135:104];

   logic [31:0] bit_m;
   logic        task_ok;
   logic [7:0]  tlow;
   logic [SLOT_W-1:0] tslot;
   logic        tok_range;
   assign bit_m     = 32'd1 << tid;
   assign task_ok   = (tid != 5'd0) && (32'(tid) < 32'(TASKS));
   assign tlow      = tok[7:0];
   assign tok_range = (tlow != 8'd0) && (32'(tlow) <= 32'(SLOTS));
   assign tslot     = SLOT_W'(tlow - 8'd1);

   assign req_tready = (state_ff == ST_IDLE) && !rspv_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rspv_ff;
   assign rsp_tdata  = rsp_ff;

   assign raddr = (state_ff == ST_IDLE || (state_ff == ST_READ)) &&
                  act != ACT_CREATE && act != ACT_CLEANUP ? tslot : cnt_ff[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   function automatic logic [95:0] pack_rsp(logic st, logic [23:0] t, logic [31:0] a,
                                            logic [16:0] s, logic [3:0] fp,
                                            logic [4:0] ps, logic [11:0] fo);
      return {1'b0, fo, ps, fp, s, a, t, st};
   endfunction

   function automatic slot_type release_idle(slot_type e);
      slot_type r;
      r = e;
      if (e.owners == 32'd0 && e.pins == 16'd0) begin
         r = '0;
         r.gen = e.gen;
      end
      return r;
   endfunction

   slot_type    e, ne;
   logic        tok_hit;
   logic [32:0] end33;
   logic [31:0] endv, lastp, firstp;
   logic [15:0] ngen;
   logic [31:0] addr;
   always_comb begin
      e       = rd_ff;
      tok_hit = tok_range && e.valid && ({8'd0, e.gen, tlow} == tok);
      end33   = 33'(off) + 33'(len);
      endv    = end33[31:0];
      firstp  = off >> PAGE_SH;
      lastp   = 32'((end33 + 33'(PAGE_BYTES - 1)) >> PAGE_SH);
      ngen    = (e.gen == 16'hFFFF) ? 16'd1 : e.gen + 16'd1;
      addr    = base_ff + 32'(cnt_ff[SLOT_W-1:0]) * SLOT_CAP[31:0];
   end

   always_comb begin
      ne       = e;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rsp_in   = rsp_ff;
      rspv_in  = rspv_ff && !rsp_tready;
      we       = 1'b0;
      waddr    = cnt_ff[SLOT_W-1:0];
      wdata    = ne;
      case (state_ff)
         ST_CLEAR: begin
            we    = 1'b1;
            wdata = '0;
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == 32'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (req_tvalid && req_tready) state_in = ST_READ;
         end
         ST_READ: begin
            rsp_in = pack_rsp(1'b1, 24'd0, 32'd0, 17'd0, 4'd0, 5'd0, 12'd0);
            state_in = ST_EXEC;
            if (act == ACT_CREATE || act == ACT_CLEANUP) begin
               if (!task_ok || (act == ACT_CREATE &&
                   (sz == 32'd0 || 33'(sz) > SLOT_CAP))) state_in = ST_OUT;
               else state_in = ST_WALK;
            end else if (act > ACT_CLEANUP) begin
               state_in = ST_OUT;
            end
         end
         ST_WALK: begin
            // rd_ff holds slot cnt_ff
            if (act == ACT_CREATE) begin
               if (!e.valid) begin
                  ne.valid  = 1'b1;
                  ne.gen    = ngen;
                  ne.size   = sz[16:0];
                  ne.pages  = 5'((33'(sz) + 33'(PAGE_BYTES - 1)) >> PAGE_SH);
                  ne.pins   = 16'd0;
                  ne.owners = bit_m;
                  wdata     = ne;
                  we        = 1'b1;
                  rsp_in    = pack_rsp(1'b0, {ngen, 8'(cnt_ff) + 8'd1}, addr, sz[16:0],
                                       4'd0, 5'd0, 12'd0);
                  state_in  = ST_OUT;
               end
            end else if (e.valid && (e.owners & bit_m) != 32'd0) begin
               ne.owners = e.owners & ~bit_m;
               wdata     = release_idle(ne);
               we        = 1'b1;
            end
            if (state_in == ST_WALK) begin
               if (32'(cnt_ff) == 32'(SLOTS - 1)) begin
                  if (act == ACT_CLEANUP)
                     rsp_in = pack_rsp(1'b0, 24'd0, 32'd0, 17'd0, 4'd0, 5'd0, 12'd0);
                  state_in = ST_OUT;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (act == ACT_CREATE || act == ACT_CLEANUP) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_OUT;
               waddr    = tslot;
               case (act)
                  ACT_MAP: begin
                     if (task_ok && tok_hit && (e.owners & bit_m) == 32'd0) begin
                        ne.owners = e.owners | bit_m;
                        we = 1'b1;
                        wdata = ne;
                        rsp_in = pack_rsp(1'b0, tok[23:0],
                                          base_ff + 32'(tslot) * SLOT_CAP[31:0],
                                          e.size, 4'd0, 5'd0, 12'd0);
                     end
                  end
                  ACT_UNMAP: begin
                     if (task_ok && tok_hit && (e.owners & bit_m) != 32'd0) begin
                        ne.owners = e.owners & ~bit_m;
                        we = 1'b1;
                        wdata = release_idle(ne);
                        rsp_in = pack_rsp(1'b0, 24'd0, 32'd0, 17'd0, 4'd0, 5'd0, 12'd0);
                     end
                  end
                  ACT_PIN: begin
                     if (task_ok && len != 32'd0 && !end33[32] && tok_hit &&
                         (e.owners & bit_m) != 32'd0 && endv <= 32'(e.size) &&
                         e.pins != 16'hFFFF && firstp < 32'(e.pages) &&
                         lastp <= 32'(e.pages) && lastp > firstp) begin
                        ne.pins = e.pins + 16'd1;
                        we = 1'b1;
                        wdata = ne;
                        rsp_in = pack_rsp(1'b0, 24'd0, 32'd0, 17'd0, firstp[3:0],
                                          5'(lastp - firstp), off[11:0]);
                     end
                  end
                  ACT_UNPIN: begin
                     if (tok_hit && e.pins != 16'd0) begin
                        ne.pins = e.pins - 16'd1;
                        we = 1'b1;
                        wdata = release_idle(ne);
                        rsp_in = pack_rsp(1'b0, 24'd0, 32'd0, 17'd0, 4'd0, 5'd0, 12'd0);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_OUT: begin
            rspv_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         rspv_ff  <= 1'b0;
         base_ff  <= 32'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rspv_ff  <= rspv_in;
         if (csr_valid) base_ff <= csr_data;
      end
      rsp_ff <= rsp_in;
      if (req_tvalid && req_tready) req_ff <= req_tdata;
   end
endmodule

FILE: bench/srht_checker.sv
// Checker for the shared region handle table: watches request, response and csr channels,
// predicts each response from a local slot table and compares field by field. Uses srht_pkg.
`timescale 1ns / 1ps
module srht_checker
   import srht_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [31:0]  csr_data,
   output int           error_count,
   output int           pending_count
);
   typedef struct packed {
      logic [11:0] first_offset;
      logic [4:0]  page_span;
      logic [3:0]  first_page;
      logic [16:0] size_out;
      logic [31:0] address;
      logic [23:0] token_out;
      logic        status;
   } region_reply;

   logic [31:0] base_addr;
   slot_type    tbl [SLOTS];
   region_reply replies_due[$];

   function automatic bit task_valid(logic [4:0] t);
      return t >= 1 && t < TASKS;
   endfunction

   function automatic int lookup(logic [31:0] tok);
      int low;
      low = tok[7:0];
      if (low == 0 || low > SLOTS) return -1;
      if (!tbl[low-1].valid || {8'd0, tbl[low-1].gen, 8'(low)} != tok) return -1;
      return low - 1;
   endfunction

   function automatic void free_if_idle(int i);
      if (tbl[i].owners == 0 && tbl[i].pins == 0) begin
         tbl[i].valid = 0;
         tbl[i].size = 0;
         tbl[i].pages = 0;
      end
   endfunction

   function automatic region_reply predict_reply(logic [135:0] d);
      region_reply r;
      logic [2:0]  act;
      logic [4:0]  tid;
      logic [31:0] tok, sz, ofs, len, bitm;
      logic [32:0] fin, first, last;
      int s;
      act = d[2:0];
      tid = d[7:3];
      tok = d[39:8];
      sz = d[71:40];
      ofs = d[103:72];
      len = d[135:104];
      bitm = 32'd1 << tid;
      r = '0;
      r.status = 1;
      case (act)
         ACT_CREATE: begin
            if (task_valid(tid) && sz != 0 && {1'b0, sz} <= SLOT_CAP) begin
               s = -1;
               for (int i = SLOTS - 1; i >= 0; i--) if (!tbl[i].valid) s = i;
               if (s >= 0) begin
                  tbl[s].gen = tbl[s].gen + 1;
                  if (tbl[s].gen == 0) tbl[s].gen = 1;
                  tbl[s].valid = 1;
                  tbl[s].size = sz[16:0];
                  tbl[s].pages = 5'((sz + PAGE_BYTES - 1) / PAGE_BYTES);
                  tbl[s].pins = 0;
                  tbl[s].owners = bitm;
                  r.status = 0;
                  r.token_out = {tbl[s].gen, 8'(s + 1)};
                  r.address = base_addr + 32'(s) * 32'(SLOT_CAP);
                  r.size_out = tbl[s].size;
               end
            end
         end
         ACT_MAP: begin
            s = lookup(tok);
            if (task_valid(tid) && s >= 0 && (tbl[s].owners & bitm) == 0) begin
               tbl[s].owners |= bitm;
               r.status = 0;
               r.token_out = tok[23:0];
               r.address = base_addr + 32'(s) * 32'(SLOT_CAP);
               r.size_out = tbl[s].size;
            end
         end
         ACT_UNMAP: begin
            s = lookup(tok);
            if (task_valid(tid) && s >= 0 && (tbl[s].owners & bitm) != 0) begin
               tbl[s].owners &= ~bitm;
               free_if_idle(s);
               r.status = 0;
            end
         end
         ACT_PIN: begin
            s = lookup(tok);
            fin = {1'b0, ofs} + {1'b0, len};
            if (task_valid(tid) && len != 0 && fin <= 33'hFFFFFFFF && s >= 0) begin
               first = ofs / PAGE_BYTES;
               last = (fin + PAGE_BYTES - 1) / PAGE_BYTES;
               if ((tbl[s].owners & bitm) != 0 && fin <= tbl[s].size && tbl[s].pins != 16'hFFFF
                   && first < tbl[s].pages && last <= tbl[s].pages && last > first) begin
                  tbl[s].pins++;
                  r.status = 0;
                  r.first_page = first[3:0];
                  r.page_span = 5'(last - first);
                  r.first_offset = ofs[11:0];
               end
            end
         end
         ACT_UNPIN: begin
            s = lookup(tok);
            if (s >= 0 && tbl[s].pins != 0) begin
               tbl[s].pins--;
               free_if_idle(s);
               r.status = 0;
            end
         end
         ACT_CLEANUP: begin
            if (task_valid(tid)) begin
               for (int i = 0; i < SLOTS; i++)
                  if (tbl[i].valid && (tbl[i].owners & bitm) != 0) begin
                     tbl[i].owners &= ~bitm;
                     free_if_idle(i);
                  end
               r.status = 0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   assign pending_count = replies_due.size();

   always @(posedge clock) begin
      region_reply got, want;
      if (reset) begin
         base_addr = '0;
         for (int i = 0; i < SLOTS; i++) tbl[i] = '0;
         replies_due.delete();
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) base_addr = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[94:0];
            if (replies_due.size() == 0) begin
               $error("response with nothing outstanding: %h", got);
               error_count <= error_count + 1;
            end else begin
               want = replies_due.pop_front();
               if (got !== want) begin
                  error_count <= error_count + 1;
                  if (got.status !== want.status)
                     $error("status exp %h got %h", want.status, got.status);
                  if (got.token_out !== want.token_out)
                     $error("token_out exp %h got %h", want.token_out, got.token_out);
                  if (got.address !== want.address)
                     $error("address exp %h got %h", want.address, got.address);
                  if (got.size_out !== want.size_out)
                     $error("size_out exp %h got %h", want.size_out, got.size_out);
                  if (got.first_page !== want.first_page)
                     $error("first_page exp %h got %h", want.first_page, got.first_page);
                  if (got.page_span !== want.page_span)
                     $error("page_span exp %h got %h", want.page_span, got.page_span);
                  if (got.first_offset !== want.first_offset)
                     $error("first_offset exp %h got %h", want.first_offset,
                            got.first_offset);
               end
            end
         end
         if (req_tvalid && req_tready) replies_due.push_back(predict_reply(req_tdata));
      end
   end
endmodule

FILE: bench/tb_shared_region_handle_table_top.sv
// Top of the shared region handle table bench: clock, reset, request and csr stimulus,
// response back-pressure and verdict. Depends on srht_pkg and srht_checker.
`timescale 1ns / 1ps
module tb_shared_region_handle_table_top;
   import srht_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [95:0]  rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [31:0]  csr_data = '0;
   int           error_count, pending_count;
   int           gap_pct = 0, stall_pct = 0;
   int           idle_cycles = 0;
   logic [23:0]  live_tokens[$];

   always #5 clock = ~clock;

   shared_region_handle_table_top DUT (.*);

   srht_checker checker_i (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (rsp_tvalid && rsp_tready && rsp_tdata[0] == 0 && rsp_tdata[24:1] != 0) begin
         if (live_tokens.size() > 40) void'(live_tokens.pop_front());
         live_tokens.push_back(rsp_tdata[24:1]);
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   task automatic send_request(logic [2:0] act, logic [4:0] tid, logic [31:0] tok,
                               logic [31:0] sz, logic [31:0] ofs, logic [31:0] len);
      do @(negedge clock); while ($urandom_range(99) < gap_pct);
      req_tdata <= {len, ofs, sz, tok, tid, act};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   task automatic write_base(logic [31:0] value);
      while (pending_count != 0) @(negedge clock);
      repeat (2 * SLOTS + 8) @(negedge clock);
      csr_data <= value;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] pick_token();
      logic [31:0] t;
      if (live_tokens.size() != 0 && $urandom_range(9) < 8)
         t = {8'd0, live_tokens[$urandom_range(live_tokens.size() - 1)]};
      else
         t = $urandom();
      if ($urandom_range(19) == 0) t = t ^ (32'd1 << $urandom_range(31));
      return t;
   endfunction

   task automatic random_request();
      logic [2:0]  act;
      logic [4:0]  tid;
      logic [31:0] sz, ofs, len;
      int          pick;
      pick = $urandom_range(99);
      act = pick < 20 ? ACT_CREATE : pick < 35 ? ACT_MAP : pick < 50 ? ACT_UNMAP :
            pick < 72 ? ACT_PIN : pick < 90 ? ACT_UNPIN : pick < 95 ? ACT_CLEANUP :
            3'($urandom_range(7));
      tid = ($urandom_range(19) == 0) ? 5'd0 : 5'($urandom_range(1, 6));
      if ($urandom_range(9) == 0) tid = 5'($urandom());
      sz = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1, 32'(SLOT_CAP));
      ofs = $urandom_range(32'(SLOT_CAP));
      len = $urandom_range(1, 20000);
      if ($urandom_range(14) == 0) begin
         ofs = $urandom();
         len = $urandom();
      end
      send_request(act, tid, pick_token(), sz, ofs, len);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_base(32'hFFFF_FFFF);
      send_request(ACT_CREATE, 5'd1, 0, 32'd1, 0, 0);
      send_request(ACT_CREATE, 5'd31, 0, 32'(SLOT_CAP), 0, 0);
      send_request(ACT_CREATE, 5'd2, 0, 32'(SLOT_CAP + 1), 0, 0);
      send_request(ACT_CREATE, 5'd2, 0, 32'd0, 0, 0);
      send_request(ACT_CREATE, 5'd0, 0, 32'd100, 0, 0);
      send_request(ACT_MAP, 5'd3, 32'h0000_0101, 0, 0, 0);
      send_request(ACT_MAP, 5'd3, 32'h0000_0101, 0, 0, 0);
      send_request(ACT_MAP, 5'd4, 32'hFF00_0101, 0, 0, 0);
      send_request(ACT_PIN, 5'd31, 32'h0000_0102, 0, 32'd4095, 32'd2);
      send_request(ACT_PIN, 5'd31, 32'h0000_0102, 0, 32'(SLOT_CAP - 1), 32'd1);
      send_request(ACT_PIN, 5'd31, 32'h0000_0102, 0, 32'hFFFF_FFFF, 32'd1);
      send_request(ACT_PIN, 5'd31, 32'h0000_0102, 0, 0, 32'd0);
      send_request(ACT_PIN, 5'd5, 32'h0000_0102, 0, 0, 32'd1);
      send_request(ACT_UNMAP, 5'd31, 32'h0000_0102, 0, 0, 0);
      send_request(ACT_UNPIN, 5'd0, 32'h0000_0102, 0, 0, 0);
      send_request(ACT_UNPIN, 5'd0, 32'h0000_0102, 0, 0, 0);
      send_request(ACT_UNPIN, 5'd0, 32'h0000_0102, 0, 0, 0);
      send_request(ACT_UNPIN, 5'd0, 32'h0000_0102, 0, 0, 0);
      send_request(ACT_UNMAP, 5'd2, 32'h0000_0101, 0, 0, 0);
      send_request(ACT_CLEANUP, 5'd0, 0, 0, 0, 0);
      send_request(ACT_CLEANUP, 5'd1, 0, 0, 0, 0);
      send_request(3'd6, 5'd3, 32'h0000_0101, 0, 0, 0);
      send_request(3'd7, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(ACT_CLEANUP, 5'd3, 0, 0, 0, 0);
      for (int phase = 0; phase < 4; phase++) begin
         gap_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 33 : 82) : 0;
         stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 33 : 82) : 0;
         write_base(phase == 0 ? 32'd0 : phase == 1 ? 32'h8000_0000 : $urandom());
         for (int n = 0; n < 350; n++) begin
            if (n % 70 == 69) send_request(ACT_CLEANUP, 5'($urandom_range(1, 6)), 0, 0, 0, 0);
            random_request();
         end
      end
      gap_pct = 0;
      stall_pct = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (2 * SLOTS + 8) @(negedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

FILE: filelist.f
sv/srht_pkg.sv
sv/shared_region_handle_table_top.sv
bench/srht_checker.sv
bench/tb_shared_region_handle_table_top.sv
